[hw/rtl/bed_pkg.sv]
// Package for the backslash escape decoder.
// Holds the decode mode encoding, character constants and the result word type.
// No dependencies.
`timescale 1ns / 1ps

package bed_pkg;

  // Decode modes. Codes 5 to 7 are never produced and act as plain text.
  typedef enum logic [2:0] {
    MODE_TEXT = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_OCT1 = 3'd2,
    MODE_OCT2 = 3'd3,
    MODE_HEX  = 3'd4
  } bed_mode_t;

  // Source characters that steer the decoder.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_A     = 8'h61;

  // Control bytes that the simple escapes decode to.
  localparam logic [7:0] CTL_LF   = 8'h0A;
  localparam logic [7:0] CTL_TAB  = 8'h09;
  localparam logic [7:0] CTL_CR   = 8'h0D;
  localparam logic [7:0] CTL_FF   = 8'h0C;
  localparam logic [7:0] CTL_BS   = 8'h08;
  localparam logic [7:0] CTL_VT   = 8'h0B;
  localparam logic [7:0] CTL_BEL  = 8'h07;

  // Depth of the result queue; one byte can cause at most two words.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One result word.
  typedef struct packed {
    logic [7:0] out_char;
    logic       is_end;
  } bed_res_t;

endpackage

[hw/rtl/bed_if.sv]
// Valid/ready channel interfaces for the backslash escape decoder.
// bed_in_if carries source bytes, bed_out_if carries decoded words.
// No dependencies.
`timescale 1ns / 1ps

interface bed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

interface bed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       is_end;

  modport source (output valid, output out_char, output is_end, input ready);
  modport sink (input valid, input out_char, input is_end, output ready);
endinterface

[hw/rtl/backslash_escape_decoder_core.sv]
// Backslash escape decoder, top level.
// Depends on bed_pkg and the channel interfaces in bed_if.sv.
//
// Usage:
//   in_ch  (sink)   : one source byte per word; a zero byte ends the string.
//   out_ch (source) : decoded bytes; the word with is_end set closes the string
//                     and carries out_char of zero.
// A source byte is taken into an input register, decoded there by a short
// combinational step against the decode mode and the octal/hex accumulator,
// and its zero, one or two result words are written into a two-entry output
// queue, from whose head out_ch is driven. Throughput is one byte per cycle
// while the queue has room for the words of the byte in the input register.
// A byte that flushes a pending octal or hex value gives two words, which the
// single output port drains one at a time; the queue absorbs them or holds
// back the input by dropping in_ch.ready.
// When the receiver stalls, the queue fills and in_ch.ready drops once the
// word in the input register has no room; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the queue and the input register and
// returns the decoder to plain text mode with a zero accumulator.
`timescale 1ns / 1ps

module backslash_escape_decoder_core
  import bed_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  bed_in_if.sink       in_ch,
  bed_out_if.source    out_ch
);

  // Input register.
  logic       byte_vld_r;
  logic [7:0] byte_r;

  // Decoder state.
  bed_mode_t  mode_r, mode_nxt;
  logic [7:0] acc_r, acc_nxt;

  // Output queue, entry 0 is the head.
  bed_res_t   q_r [QUEUE_DEPTH];
  bed_res_t   q_nxt [QUEUE_DEPTH];
  logic [1:0] cnt_r, cnt_nxt;

  // Decode results for the byte in the input register.
  logic [1:0] n_res;
  bed_res_t   res0, res1;

  logic       is_oct, is_hex;
  logic [3:0] hex_val;
  logic       adv, pop, fits;

  // Digit classification.
  always_comb begin
    is_oct  = (byte_r >= 8'h30) && (byte_r <= 8'h37);
    is_hex  = 1'b0;
    hex_val = byte_r[3:0];
    if ((byte_r >= 8'h30) && (byte_r <= 8'h39)) begin
      is_hex = 1'b1;
    end else if (((byte_r >= 8'h61) && (byte_r <= 8'h66)) ||
                 ((byte_r >= 8'h41) && (byte_r <= 8'h46))) begin
      is_hex  = 1'b1;
      hex_val = {1'b0, byte_r[2:0]} + 4'd9;
    end
  end

  // Decode step: next mode, next accumulator and up to two result words.
  always_comb begin
    logic [7:0] flush_val;
    logic       flush;
    logic       plain;

    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    n_res     = 2'd0;
    res0      = '{out_char: CH_NUL, is_end: 1'b0};
    res1      = '{out_char: CH_NUL, is_end: 1'b0};
    flush_val = acc_r;
    flush     = 1'b0;
    plain     = 1'b0;

    unique case (mode_r)
      MODE_ESC: begin
        mode_nxt = MODE_TEXT;
        if (byte_r == CH_NUL) begin
          acc_nxt = '0;
          n_res   = 2'd1;
          res0    = '{out_char: CH_NUL, is_end: 1'b1};
        end else if (is_oct) begin
          acc_nxt  = {5'd0, byte_r[2:0]};
          mode_nxt = MODE_OCT1;
        end else if (byte_r == CH_X) begin
          acc_nxt  = '0;
          mode_nxt = MODE_HEX;
        end else if (byte_r != CH_AMP) begin
          n_res = 2'd1;
          unique case (byte_r)
            CH_N:    res0.out_char = CTL_LF;
            CH_T:    res0.out_char = CTL_TAB;
            CH_R:    res0.out_char = CTL_CR;
            CH_F:    res0.out_char = CTL_FF;
            CH_B:    res0.out_char = CTL_BS;
            CH_V:    res0.out_char = CTL_VT;
            CH_A:    res0.out_char = CTL_BEL;
            default: res0.out_char = byte_r;
          endcase
        end
      end
      MODE_OCT1, MODE_OCT2: begin
        if (is_oct) begin
          if (mode_r == MODE_OCT1) begin
            acc_nxt  = {acc_r[4:0], byte_r[2:0]};
            mode_nxt = MODE_OCT2;
          end else begin
            n_res         = 2'd1;
            res0.out_char = {acc_r[4:0], byte_r[2:0]};
            acc_nxt       = '0;
            mode_nxt      = MODE_TEXT;
          end
        end else begin
          flush = 1'b1;
        end
      end
      MODE_HEX: begin
        if (is_hex) begin
          acc_nxt = {acc_r[3:0], hex_val};
        end else begin
          flush = 1'b1;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase

    // A flush emits the pending value, then the byte is handled as text.
    if (flush) begin
      n_res         = 2'd1;
      res0.out_char = flush_val;
      acc_nxt       = '0;
      plain         = 1'b1;
    end

    // Plain text handling of the byte.
    if (plain) begin
      if (byte_r == CH_NUL) begin
        mode_nxt = MODE_TEXT;
        acc_nxt  = '0;
        if (flush) begin
          res1  = '{out_char: CH_NUL, is_end: 1'b1};
          n_res = 2'd2;
        end else begin
          res0  = '{out_char: CH_NUL, is_end: 1'b1};
          n_res = 2'd1;
        end
      end else if (byte_r == CH_BSL) begin
        mode_nxt = MODE_ESC;
      end else begin
        mode_nxt = MODE_TEXT;
        if (flush) begin
          res1  = '{out_char: byte_r, is_end: 1'b0};
          n_res = 2'd2;
        end else begin
          res0  = '{out_char: byte_r, is_end: 1'b0};
          n_res = 2'd1;
        end
      end
    end
  end

  // Handshake and room check for the decoded words.
  assign pop = out_ch.valid && out_ch.ready;

  always_comb begin
    unique case (n_res)
      2'd0:    fits = 1'b1;
      2'd1:    fits = (cnt_r != 2'd2) || pop;
      2'd2:    fits = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);
      default: fits = 1'b0;
    endcase
  end

  assign adv         = byte_vld_r && fits;
  assign in_ch.ready = !byte_vld_r || adv;

  // Next contents of the output queue: pop the head, then append.
  always_comb begin
    logic [1:0] base;

    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    base     = cnt_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
      base     = cnt_r - 2'd1;
    end
    cnt_nxt = base;
    if (adv) begin
      if (n_res != 2'd0) begin
        if (base == 2'd0) begin
          q_nxt[0] = res0;
          q_nxt[1] = res1;
        end else begin
          q_nxt[1] = res0;
        end
      end
      cnt_nxt = base + n_res;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      mode_r     <= MODE_TEXT;
      acc_r      <= '0;
      cnt_r      <= '0;
    end else begin
      if (in_ch.ready) begin
        byte_vld_r <= in_ch.valid;
      end
      if (adv) begin
        mode_r <= mode_nxt;
        acc_r  <= acc_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.in_char;
    end
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  // Output port drive from the queue head.
  assign out_ch.valid    = (cnt_r != 2'd0);
  assign out_ch.out_char = q_r[0].out_char;
  assign out_ch.is_end   = q_r[0].is_end;

endmodule

[hw/rtl/bed_checker.sv]
// Port level checks for the backslash escape decoder, bound to the top level.
// Depends on backslash_escape_decoder_core and its channel interfaces.
`timescale 1ns / 1ps

module bed_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       is_end
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(is_end))
    else $error("result word changed while stalled");

  // Reset leaves the output queue empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With no result waiting, the decoder always has room for a new byte.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output queue");

  // The end marker word carries no byte.
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_end |-> out_char == 8'h00)
    else $error("end marker with nonzero byte");

  // A byte accepted into an idle decoder cannot show a result in the next cycle.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_ready && !$past(in_valid && in_ready) |=> !out_valid)
    else $error("result word appeared without a decoded byte");

endmodule

bind backslash_escape_decoder_core bed_checker u_bed_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.out_char),
  .is_end    (out_ch.is_end)
);

[test/backslash_escape_decoder_core_tb.sv]
// Self-checking testbench for backslash_escape_decoder_core: random and directed strings with
// random stalls on both channels, checked word by word against a built-in escape decoder.
// Depends on bed_pkg and the channel interfaces in hw/rtl/bed_if.sv.
`timescale 1ns / 1ps

module backslash_escape_decoder_core_tb;
  import bed_pkg::*;

  // Digit characters that the decoder recognizes, beyond those in the package.
  localparam logic [7:0] CH_DIG0 = 8'h30;
  localparam logic [7:0] CH_DIG7 = 8'h37;
  localparam logic [7:0] CH_DIG9 = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;

  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bed_in_if  in_ch ();
  bed_out_if out_ch ();

  backslash_escape_decoder_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Source bytes waiting to be offered and decoded words waiting to arrive.
  logic [7:0] src_bytes[$];
  bed_res_t   expected_words[$];

  // Shadow decoder state.
  bed_mode_t  dec_mode = MODE_TEXT;
  logic [7:0] dec_acc = 8'h00;

  // Run controls, written only by the stimulus process.
  logic src_idle_on = 1'b1;
  logic snk_idle_on = 1'b1;
  int   hold_req = 0;

  int bytes_queued = 0;
  int bytes_taken = 0;
  int words_checked = 0;
  int strings_ended = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  function automatic int oct_digit(input logic [7:0] b);
    if (b >= CH_DIG0 && b <= CH_DIG7) return int'(b - CH_DIG0);
    return -1;
  endfunction

  function automatic int hex_digit(input logic [7:0] b);
    if (b >= CH_DIG0 && b <= CH_DIG9) return int'(b - CH_DIG0);
    if (b >= CH_A && b <= CH_F) return int'(b - CH_A) + 10;
    if (b >= CH_UA && b <= CH_UF) return int'(b - CH_UA) + 10;
    return -1;
  endfunction

  function automatic void push_word(input logic [7:0] ch, input logic last);
    bed_res_t w;
    w.out_char = ch;
    w.is_end = last;
    expected_words.push_back(w);
  endfunction

  // A byte seen in plain text, or the byte that ended an octal or hex run.
  function automatic void text_byte(input logic [7:0] b);
    if (b == CH_NUL) begin
      dec_mode = MODE_TEXT;
      dec_acc = 8'h00;
      push_word(CH_NUL, 1'b1);
    end else if (b == CH_BSL) begin
      dec_mode = MODE_ESC;
    end else begin
      dec_mode = MODE_TEXT;
      push_word(b, 1'b0);
    end
  endfunction

  // Advance the shadow decoder by one accepted byte and queue the words it gives.
  function automatic void decode_byte(input logic [7:0] b);
    int d;
    case (dec_mode)
      MODE_ESC: begin
        dec_mode = MODE_TEXT;
        if (b == CH_NUL) begin
          // A lone trailing backslash is dropped.
          dec_acc = 8'h00;
          push_word(CH_NUL, 1'b1);
        end else if (oct_digit(b) >= 0) begin
          dec_acc = 8'(oct_digit(b));
          dec_mode = MODE_OCT1;
        end else begin
          case (b)
            CH_X: begin
              dec_acc = 8'h00;
              dec_mode = MODE_HEX;
            end
            CH_AMP: ;
            CH_BSL: push_word(CH_BSL, 1'b0);
            CH_N:   push_word(CTL_LF, 1'b0);
            CH_T:   push_word(CTL_TAB, 1'b0);
            CH_R:   push_word(CTL_CR, 1'b0);
            CH_F:   push_word(CTL_FF, 1'b0);
            CH_B:   push_word(CTL_BS, 1'b0);
            CH_V:   push_word(CTL_VT, 1'b0);
            CH_A:   push_word(CTL_BEL, 1'b0);
            default: push_word(b, 1'b0);
          endcase
        end
      end
      MODE_OCT1, MODE_OCT2: begin
        d = oct_digit(b);
        if (d >= 0) begin
          dec_acc = 8'((dec_acc << 3) + d);
          if (dec_mode == MODE_OCT1) begin
            dec_mode = MODE_OCT2;
          end else begin
            dec_mode = MODE_TEXT;
            push_word(dec_acc, 1'b0);
            dec_acc = 8'h00;
          end
        end else begin
          push_word(dec_acc, 1'b0);
          dec_acc = 8'h00;
          text_byte(b);
        end
      end
      MODE_HEX: begin
        d = hex_digit(b);
        if (d >= 0) begin
          dec_acc = 8'((dec_acc << 4) + d);
        end else begin
          push_word(dec_acc, 1'b0);
          dec_acc = 8'h00;
          text_byte(b);
        end
      end
      default: text_byte(b);
    endcase
  endfunction

  // Source side: offers queued bytes, with random gaps between words.
  always @(posedge clk) begin : drive_bytes
    logic       offering;
    logic       next_valid;
    logic [7:0] next_char;
    int         src_gap;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.in_char <= 8'h00;
      src_gap = 0;
    end else begin
      offering = in_ch.valid;
      next_valid = in_ch.valid;
      next_char = in_ch.in_char;
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.in_char);
        bytes_taken++;
        offering = 1'b0;
      end
      // A word on offer is held until it is taken.
      if (!offering) begin
        if (src_gap > 0) begin
          src_gap--;
          next_valid = 1'b0;
        end else if (src_idle_on && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 5);
          next_valid = 1'b0;
        end else if (src_bytes.size() > 0) begin
          next_valid = 1'b1;
          next_char = src_bytes.pop_front();
        end else begin
          next_valid = 1'b0;
        end
      end
      in_ch.valid <= next_valid;
      in_ch.in_char <= next_char;
    end
  end

  // Result side: checks each accepted word and drives ready with random stalls.
  always @(posedge clk) begin : check_words
    bed_res_t want;
    int       snk_gap;
    int       hold_left;
    int       hold_done;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_gap = 0;
      hold_left = 0;
      hold_done = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        words_checked++;
        if (out_ch.is_end) strings_ended++;
        if (expected_words.size() == 0) begin
          error_count++;
          $display("%0t: unexpected word, expected none, got out_char %02h is_end %0b",
                   $time, out_ch.out_char, out_ch.is_end);
        end else begin
          want = expected_words.pop_front();
          if (out_ch.out_char !== want.out_char) begin
            error_count++;
            $display("%0t: out_char mismatch, expected %02h, got %02h",
                     $time, want.out_char, out_ch.out_char);
          end
          if (out_ch.is_end !== want.is_end) begin
            error_count++;
            $display("%0t: is_end mismatch, expected %0b, got %0b",
                     $time, want.is_end, out_ch.is_end);
          end
        end
      end
      // A long hold lets the decoder fill up and stall its input.
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req != hold_done) begin
        hold_done = hold_req;
        hold_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_ch.ready <= 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
        snk_gap = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      quiet_cycles++;
    else
      quiet_cycles = 0;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d words still due",
               $time, WATCHDOG_LIMIT, expected_words.size());
      $display("backslash_escape_decoder_core_tb failed");
      $finish;
    end
  end

  function automatic void push_src(input logic [7:0] b);
    src_bytes.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_src(s[i]);
  endfunction

  function automatic logic [7:0] simple_escape_char(input int k);
    case (k)
      0: return CH_BSL;
      1: return CH_N;
      2: return CH_T;
      3: return CH_R;
      4: return CH_F;
      5: return CH_B;
      6: return CH_V;
      default: return CH_A;
    endcase
  endfunction

  // Index 0..21 over the digits, lower case and upper case hex letters.
  function automatic logic [7:0] hex_char(input int k);
    if (k < 10) return 8'(CH_DIG0 + k);
    if (k < 16) return 8'(CH_A + k - 10);
    return 8'(CH_UA + k - 16);
  endfunction

  // One string of mostly well-formed escapes with random content and some noise.
  function automatic void queue_random_string();
    int tokens;
    int pick;
    int n;
    tokens = $urandom_range(1, 12);
    for (int k = 0; k < tokens; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        push_src(8'($urandom_range(1, 255)));
      end else if (pick < 55) begin
        push_src(CH_BSL);
        push_src(simple_escape_char($urandom_range(0, 7)));
      end else if (pick < 70) begin
        push_src(CH_BSL);
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) push_src(8'(CH_DIG0 + $urandom_range(0, 7)));
      end else if (pick < 82) begin
        push_src(CH_BSL);
        push_src(CH_X);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) push_src(hex_char($urandom_range(0, 21)));
        if ($urandom_range(0, 3) == 0) begin
          push_src(CH_BSL);
          push_src(CH_AMP);
        end
      end else if (pick < 88) begin
        push_src(CH_BSL);
        push_src(CH_AMP);
      end else if (pick < 95) begin
        push_src(CH_BSL);
        push_src(8'($urandom_range(1, 255)));
      end else begin
        // Noise; a zero here ends the string early.
        push_src(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 7) == 0) push_src(CH_BSL);
    push_src(CH_NUL);
  endfunction

  task automatic fill_to(input int target);
    while (bytes_queued < target) queue_random_string();
  endtask

  // Waits until every queued byte is taken and every word has come.
  task automatic wait_drained();
    while (src_bytes.size() != 0 || in_ch.valid || expected_words.size() != 0)
      @(negedge clk);
  endtask

  // Stimulus sequence and final verdict.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_char = 8'h00;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: byte extremes, every simple escape, octal overflow, a decoded zero
    // flushed by a new escape, a long hex run ended by a backslash and an ampersand,
    // hex without digits, an unknown escape, a flush together with the end of the
    // string, and a lone trailing backslash.
    push_src(8'hFF);
    push_src(8'h01);
    push_text("\\\\\\n\\t\\r\\f\\b\\v\\a");
    push_text("\\777\\0\\x1fF\\&\\xg\\q\\12");
    push_src(CH_NUL);
    push_src(CH_BSL);
    push_src(CH_NUL);
    wait_drained();

    fill_to(600);
    wait_drained();

    // Receiver holds off while the sender keeps offering.
    hold_req++;
    fill_to(1000);
    wait_drained();

    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    fill_to(1400);
    wait_drained();

    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    fill_to(1750);
    hold_req++;
    wait_drained();

    // Closing stretch runs at full rate on both sides.
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    fill_to(1950);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_words.size() != 0) begin
      error_count++;
      $display("%0t: %0d words never arrived", $time, expected_words.size());
    end
    $display("Decoded %0d source bytes into %0d words over %0d strings, %0d errors.",
             bytes_taken, words_checked, strings_ended, error_count);
    if (error_count == 0)
      $display("backslash_escape_decoder_core_tb passed");
    else
      $display("backslash_escape_decoder_core_tb failed");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/bed_pkg.sv
hw/rtl/bed_if.sv
hw/rtl/backslash_escape_decoder_core.sv
hw/rtl/bed_checker.sv
test/backslash_escape_decoder_core_tb.sv
